FILE: rtl/lkt_pkg.sv
// Shared constants and types for the LRU key tracker.
// No dependencies; used by lkt_cell and lru_key_tracker.
package lkt_pkg;

    localparam int ENTRIES = 64;
    localparam int KEY_W   = 64;
    localparam int CAP_W   = 7;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    // Register indexes, taken from paddr[2].
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic cmp;
        logic shift;
    } cell_ctrl_t;

endpackage

FILE: rtl/lkt_cell.sv
// One slot of the recency chain: a key, its valid bit and a match flag.
// Depends on lkt_pkg.
module lkt_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lkt_pkg::cell_ctrl_t       ctrl,
    input  logic [lkt_pkg::KEY_W-1:0] cmp_key,
    input  logic [lkt_pkg::KEY_W-1:0] prev_key,
    input  logic                      prev_valid,
    output logic [lkt_pkg::KEY_W-1:0] key_q,
    output logic                      valid_q,
    output logic                      match_q
);
    import lkt_pkg::*;

    logic [KEY_W-1:0] key_reg;
    logic             valid_reg;
    logic             match_reg;

    // Key storage needs no reset: an entry is only looked at while valid.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            key_reg <= prev_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.shift)
            begin
                valid_reg <= valid_reg | prev_valid;
            end
            if (ctrl.cmp)
            begin
                match_reg <= valid_reg && (key_reg == cmp_key);
            end
        end
    end

    assign key_q   = key_reg;
    assign valid_q = valid_reg;
    assign match_q = match_reg;

endmodule

FILE: rtl/lru_key_tracker.sv
// LRU key tracker: a chain of compare-and-shift cells holding keys, most recent first.
// The compare is registered as a key is taken; the chain update and the result register follow in S_UPD.
// No new key is taken until S_UPD is done; the compare and the chain shift are separate steps.
// A finished result waits in the output register while the next beat is taken.
// Reset (rst_n, asynchronous, active low) empties the chain and sets capacity to 64.
// Depends on lkt_pkg and lkt_cell.
module lru_key_tracker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lkt_pkg::KEY_W-1:0]   key,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        hit,
    output logic                        evicted,
    output logic [lkt_pkg::KEY_W-1:0]   evicted_key,
    output logic                        rejected,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lkt_pkg::PADDR_W-1:0] paddr,
    input  logic [lkt_pkg::PDATA_W-1:0] pwdata,
    output logic [lkt_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import lkt_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE,
        S_UPD
    } state_t;

    state_t           state_reg, state_next;
    logic [KEY_W-1:0] probe_reg, probe_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [CAP_W-1:0] cap_reg, cap_next;
    logic             out_valid_reg, out_valid_next;
    logic             hit_reg, hit_next;
    logic             evicted_reg, evicted_next;
    logic [KEY_W-1:0] evicted_key_reg, evicted_key_next;
    logic             rejected_reg, rejected_next;

    logic [KEY_W-1:0]   cell_key   [ENTRIES];
    logic [ENTRIES-1:0] valid_vec;
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] shift_vec;
    logic [ENTRIES-1:0] last_vec;
    logic [ENTRIES:0]   hit_mask;
    logic [KEY_W-1:0]   oldest_key;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   eff_cap;
    logic               is_full;
    logic               any_hit;
    logic               probe_zero;
    logic               in_fire;
    logic               do_update;
    logic               cfg_write;

    assign in_ready   = (state_reg == S_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign do_update  = (state_reg == S_UPD) && (!out_valid_reg || out_ready);
    assign probe_zero = (probe_reg == '0);
    assign any_hit    = |match_vec;

    assign cap_ext = CMP_W'(cap_reg);
    assign eff_cap = (cap_ext == '0) ? CMP_W'(1)
                   : ((cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext);
    assign is_full = CMP_W'(occ_reg) >= eff_cap;

    // The match vector is one-hot on a hit, so subtracting one from it shifted up
    // gives ones over every slot from the front down to the hit slot.
    assign hit_mask = {match_vec, 1'b0} - (ENTRIES + 1)'(1);

    always_comb
    begin
        if (any_hit)
        begin
            shift_vec = hit_mask[ENTRIES-1:0];
        end
        else if (is_full)
        begin
            shift_vec = valid_vec | ENTRIES'(1);
        end
        else
        begin
            shift_vec = {valid_vec[ENTRIES-2:0], 1'b1};
        end
    end

    // The oldest key sits in the last valid slot of the prefix.
    always_comb
    begin
        oldest_key = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (i == ENTRIES - 1)
            begin
                last_vec[i] = valid_vec[i];
            end
            else
            begin
                last_vec[i] = valid_vec[i] && !valid_vec[i+1];
            end
            oldest_key = oldest_key | (cell_key[i] & {KEY_W{last_vec[i]}});
        end
    end

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        cell_ctrl_t       ctrl;
        logic [KEY_W-1:0] prev_key;
        logic             prev_valid;

        assign ctrl.cmp   = in_fire;
        assign ctrl.shift = do_update && !probe_zero && shift_vec[g];

        if (g == 0)
        begin : g_front
            assign prev_key   = probe_reg;
            assign prev_valid = 1'b1;
        end
        else
        begin : g_rest
            assign prev_key   = cell_key[g-1];
            assign prev_valid = valid_vec[g-1];
        end

        lkt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .cmp_key    (key),
            .prev_key   (prev_key),
            .prev_valid (prev_valid),
            .key_q      (cell_key[g]),
            .valid_q    (valid_vec[g]),
            .match_q    (match_vec[g])
        );
    end

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_CAPACITY) ? PDATA_W'(cap_reg) : '0;

    always_comb
    begin
        state_next       = state_reg;
        probe_next       = probe_reg;
        occ_next         = occ_reg;
        cap_next         = cap_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        hit_next         = hit_reg;
        evicted_next     = evicted_reg;
        evicted_key_next = evicted_key_reg;
        rejected_next    = rejected_reg;

        if (cfg_write && (paddr[2] == REG_CAPACITY))
        begin
            cap_next = pwdata[CAP_W-1:0];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    probe_next = key;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                if (do_update)
                begin
                    out_valid_next   = 1'b1;
                    rejected_next    = probe_zero;
                    hit_next         = !probe_zero && any_hit;
                    evicted_next     = !probe_zero && !any_hit && is_full;
                    evicted_key_next = (!probe_zero && !any_hit && is_full) ? oldest_key : '0;
                    if (!probe_zero && !any_hit && !is_full)
                    begin
                        occ_next = occ_reg + OCC_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            probe_reg       <= '0;
            occ_reg         <= '0;
            cap_reg         <= CAP_RESET;
            out_valid_reg   <= 1'b0;
            hit_reg         <= 1'b0;
            evicted_reg     <= 1'b0;
            evicted_key_reg <= '0;
            rejected_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            probe_reg       <= probe_next;
            occ_reg         <= occ_next;
            cap_reg         <= cap_next;
            out_valid_reg   <= out_valid_next;
            hit_reg         <= hit_next;
            evicted_reg     <= evicted_next;
            evicted_key_reg <= evicted_key_next;
            rejected_reg    <= rejected_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;
    assign rejected    = rejected_reg;

    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(occ_reg))
        else $error("occupancy count disagrees with the valid cells");

    a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> $onehot0(match_vec))
        else $error("more than one cell matched the key");

    a_hit_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (do_update && (any_hit || is_full || probe_zero)) |=> $stable(occ_reg))
        else $error("occupancy changed on a hit, eviction or rejected beat");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for lru_key_tracker: keys are driven in beats and each result
// beat is compared against an in-bench recency model; the capacity register is set over APB.
// Depends on rtl/lkt_pkg.sv and rtl/lru_key_tracker.sv.
`timescale 1ns / 100ps

module tb;

    import lkt_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int POOL_MAX = 128;
    localparam logic [PADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

    typedef struct packed {
        logic             hit;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
        logic             rejected;
    } touch_result_t;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [KEY_W-1:0]    key         = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic                hit;
    logic                evicted;
    logic [KEY_W-1:0]    evicted_key;
    logic                rejected;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [PDATA_W-1:0]  pwdata      = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Model of the tracker: slot 0 holds the most recent key.
    logic [KEY_W-1:0]    lru_keys [ENTRIES];
    int unsigned         held;
    logic [CAP_W-1:0]    capacity_reg;

    touch_result_t       pending_results [$];
    logic [KEY_W-1:0]    key_pool [POOL_MAX];
    int unsigned         send_idle_pct;
    int unsigned         recv_stall_pct;
    int unsigned         hold_off_cycles;
    int unsigned         errors;

    lru_key_tracker dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .key         (key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .hit         (hit),
        .evicted     (evicted),
        .evicted_key (evicted_key),
        .rejected    (rejected),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int unsigned effective_capacity();
        int unsigned c;
        c = capacity_reg;
        if (c == 0)
            c = 1;
        if (c > ENTRIES)
            c = ENTRIES;
        return c;
    endfunction

    // Slots 0..last-1 move back by one and k takes the front.
    function automatic void insert_at_head(int unsigned last, logic [KEY_W-1:0] k);
        int unsigned i;
        if (last >= ENTRIES)
            last = ENTRIES - 1;
        for (i = last; i > 0; i--)
            lru_keys[i] = lru_keys[i-1];
        lru_keys[0] = k;
    endfunction

    function automatic touch_result_t predict_touch(logic [KEY_W-1:0] k);
        touch_result_t r;
        int unsigned   i;
        r = '0;
        if (k == '0)
        begin
            r.rejected = 1'b1;
            return r;
        end
        for (i = 0; i < held; i++)
        begin
            if (lru_keys[i] == k)
            begin
                insert_at_head(i, k);
                r.hit = 1'b1;
                return r;
            end
        end
        if (held < effective_capacity())
        begin
            insert_at_head(held, k);
            held++;
        end
        else
        begin
            // Also covers a capacity lowered below the occupancy: only the
            // oldest key goes and the occupancy stays where it was.
            r.evicted     = 1'b1;
            r.evicted_key = lru_keys[held-1];
            insert_at_head(held - 1, k);
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(int unsigned pool_n);
        int unsigned      r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(99);
        if (r < 3)
            k = '0;
        else if (r < 12)
            k = {$urandom, $urandom};
        else if (r < 30 && held != 0)
            k = lru_keys[$urandom_range(held - 1)];
        else
            k = key_pool[$urandom_range(pool_n - 1)];
        return k;
    endfunction

    function automatic void refill_pool();
        int unsigned i;
        for (i = 0; i < POOL_MAX; i++)
        begin
            key_pool[i] = {$urandom, $urandom};
            if (key_pool[i] == '0)
                key_pool[i] = 64'h1;
        end
    endfunction

    // Offers one key beat and books its expected result once it is taken.
    task automatic send_key(input logic [KEY_W-1:0] k);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        key      <= k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predict_touch(k));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= {$urandom} & ~PDATA_W'(2**CAP_W - 1) | PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        capacity_reg = value;
    endtask

    // Result side: checks each beat against the oldest booked result.
    initial
    begin : result_checker
        touch_result_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    exp_r = pending_results[0];
                    pending_results.delete(0);
                    if (hit !== exp_r.hit)
                    begin
                        $error("hit: expected %0b, got %0b", exp_r.hit, hit);
                        errors++;
                    end
                    if (evicted !== exp_r.evicted)
                    begin
                        $error("evicted: expected %0b, got %0b", exp_r.evicted, evicted);
                        errors++;
                    end
                    if (evicted_key !== exp_r.evicted_key)
                    begin
                        $error("evicted_key: expected %h, got %h", exp_r.evicted_key,
                               evicted_key);
                        errors++;
                    end
                    if (rejected !== exp_r.rejected)
                    begin
                        $error("rejected: expected %0b, got %0b", exp_r.rejected, rejected);
                        errors++;
                    end
                end
            end
            if (hold_off_cycles != 0)
            begin
                hold_off_cycles--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic test_reject_and_hits();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_key('0);
        send_key('1);
        send_key(64'h1);
        send_key(64'h8000_0000_0000_0000);
        send_key(64'h5555_aaaa_5555_aaaa);
        send_key('0);
        send_key(64'h1);
        send_key('1);
        send_key('1);
        send_key(64'haaaa_5555_aaaa_5555);
    endtask

    task automatic test_small_capacity();
        // Five keys are held, so a capacity of one is below the occupancy.
        set_capacity(CAP_W'(1));
        send_key(64'h0123_4567_89ab_cdef);
        send_key(64'hfedc_ba98_7654_3210);
        send_key(64'hfedc_ba98_7654_3210);
        send_key('0);
        set_capacity(CAP_W'(0));
        send_key(64'h0000_0000_0000_0002);
        send_key(64'h0000_0000_0000_0003);
        send_key(64'h0000_0000_0000_0002);
        set_capacity(CAP_W'(2));
        send_key(64'h7fff_ffff_ffff_ffff);
        send_key(64'h0000_0000_0000_0003);
    endtask

    task automatic test_capacity_saturation();
        int unsigned i;
        set_capacity(CAP_W'(127));
        for (i = 0; i < ENTRIES + 8; i++)
            send_key({$urandom | 32'h1, $urandom});
        for (i = 0; i < 12; i++)
            if (held != 0)
                send_key(lru_keys[$urandom_range(held - 1)]);
    endtask

    task automatic test_random_traffic(input int unsigned mode);
        logic [CAP_W-1:0] cap_plan [16];
        int unsigned      j;
        int unsigned      pool_n;
        cap_plan = '{7'd64, 7'd1, 7'd16, 7'd127,
                     7'd0, 7'd5, 7'd65, 7'd32,
                     7'd3, 7'd64, 7'd2, 7'd48,
                     7'd8, 7'd127, 7'd1, 7'd64};
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
        endcase
        for (j = 0; j < 4; j++)
        begin
            if (mode == 3 && j == 0)
                set_capacity(CAP_W'($urandom_range(1, ENTRIES)));
            else
                set_capacity(cap_plan[mode*4 + j]);
            refill_pool();
            pool_n = effective_capacity() + $urandom_range(1, effective_capacity() + 8);
            if (pool_n > POOL_MAX)
                pool_n = POOL_MAX;
            repeat (100) send_key(pick_key(pool_n));
        end
    endtask

    task automatic test_output_backpressure();
        set_capacity(CAP_W'(4));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        refill_pool();
        // The receiver stays off long enough for the block to fill and drop in_ready.
        hold_off_cycles = 120;
        repeat (30) send_key(pick_key(8));
    endtask

    initial
    begin
        errors          = 0;
        held            = 0;
        capacity_reg    = CAP_RESET;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        foreach (lru_keys[i])
            lru_keys[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reject_and_hits();
        test_small_capacity();
        test_capacity_saturation();
        test_random_traffic(0);
        test_random_traffic(1);
        test_random_traffic(2);
        test_random_traffic(3);
        test_output_backpressure();

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
